[rtl/hc5_pkg.sv]
package hc5_pkg;
	localparam int PIXEL_BITS = 16;
	localparam int NUM_TAPS = 5;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 17;
	localparam int SUM_BITS = 36;
	localparam int NUM_BITS = 54;
	localparam int QUO_BITS = 38;

	localparam logic [CFG_IDX_BITS-1:0] REG_COEF4 = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIAS = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX = 3'd7;

	typedef struct packed {
		logic load;      // new source pixel into the window
		logic flush;     // virtual right-edge copy
		logic mac_clr;   // clear accumulator
		logic mac_step;  // one tap
		logic div_start;
		logic div_step;
		logic emit;      // result into output register
		logic last;
	} hc5_cmd_t;

	typedef struct packed {
		logic can_emit;  // row_count was saturated before the last shift
		logic div_done;
		logic out_busy;
	} hc5_sts_t;
endpackage

[rtl/hc5_datapath.sv]
module hc5_datapath
	import hc5_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  hc5_cmd_t                   cmd,
	output hc5_sts_t                   sts,
	input  logic [2:0]                 tap,
	input  logic [PIXEL_BITS-1:0]      px,
	input  logic signed [15:0]         coef [NUM_TAPS],
	input  logic [15:0]                divisor,
	input  logic signed [16:0]         bias,
	input  logic [15:0]                max_value,
	input  logic                       row_clear,
	input  logic                       out_take,
	output logic                       out_valid,
	output logic [15:0]                out_pixel,
	output logic                       out_row_end
);
	logic [PIXEL_BITS-1:0] win_q [4];
	logic [PIXEL_BITS-1:0] cur_q;
	logic [1:0] cnt_q;
	logic emit_q;
	logic signed [SUM_BITS-1:0] acc_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic neg_q;
	logic [5:0] dcnt_q;
	logic [PIXEL_BITS-1:0] tsel;
	logic signed [16+PIXEL_BITS+1:0] prod;
	logic [16:0] d_ext;
	logic signed [34:0] bd;
	logic signed [NUM_BITS-1:0] num;
	logic [NUM_BITS:0] trial;
	logic [15:0] lim;
	logic signed [QUO_BITS:0] q;

	assign sts.can_emit = emit_q;
	assign sts.div_done = (dcnt_q == 6'd0);
	assign sts.out_busy = out_valid;

	always_comb begin
		tsel = (tap == 3'd4) ? cur_q : win_q[tap[1:0]];
		prod = coef[tap] * $signed({2'b0, tsel});
		d_ext = (divisor == 16'd0) ? 17'd1 : {1'b0, divisor};
		bd = bias * $signed({1'b0, d_ext});
		num = ((NUM_BITS'(acc_q) + NUM_BITS'(bd)) <<< 1) + NUM_BITS'($signed({1'b0, d_ext}));
		trial = {1'b0, rem_q}
			- ({{(NUM_BITS-17){1'b0}}, d_ext, 1'b0} << (dcnt_q - 6'd1));
		lim = (PIXEL_BITS >= 16 || max_value < 16'((1 << PIXEL_BITS) - 1))
			? max_value : 16'((1 << PIXEL_BITS) - 1);
		// floor for negative numerators: -(ceil(|n|/d))
		q = neg_q ? -$signed({1'b0, quo_q}) - ((rem_q != '0) ? 1 : 0) : $signed({1'b0, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			cur_q <= '0;
			cnt_q <= '0;
			emit_q <= 1'b0;
			dcnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load || cmd.flush) begin
				logic [PIXEL_BITS-1:0] v;
				v = cmd.load ? px : cur_q;
				cur_q <= v;
				for (int i = 0; i < 3; i++) win_q[i] <= (cnt_q == 0) ? v : win_q[i+1];
				win_q[3] <= (cnt_q == 0) ? v : cur_q;
				emit_q <= (cnt_q == 2'd2);
				if (cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
			end
			if (row_clear) cnt_q <= '0;
			if (cmd.div_start) dcnt_q <= 6'd37;
			else if (cmd.div_step && dcnt_q != 0) dcnt_q <= dcnt_q - 6'd1;
			if (out_take) out_valid <= 1'b0;
			if (cmd.emit) out_valid <= 1'b1;
		end
	end

	// window shift happens before the taps are read, so the shifted window
	// holds taps 0..3 and cur_q tap 4
	always_ff @(posedge clk) begin
		if (cmd.mac_clr) acc_q <= '0;
		else if (cmd.mac_step) acc_q <= acc_q + SUM_BITS'(prod);
		if (cmd.div_start) begin
			neg_q <= num[NUM_BITS-1];
			rem_q <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
			quo_q <= '0;
		end else if (cmd.div_step && dcnt_q != 0) begin
			if (!trial[NUM_BITS]) begin
				rem_q <= trial[NUM_BITS-1:0];
				quo_q <= quo_q | (QUO_BITS'(1) << (dcnt_q - 6'd1));
			end
		end
		if (cmd.emit) begin
			out_row_end <= cmd.last;
			if (q < 0) out_pixel <= '0;
			else if (q > $signed({23'b0, lim})) out_pixel <= lim;
			else out_pixel <= q[15:0];
		end
	end
endmodule

[rtl/hc5_ctrl.sv]
module hc5_ctrl
	import hc5_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      in_last,
	input  hc5_sts_t  sts,
	output hc5_cmd_t  cmd,
	output logic [2:0] tap,
	output logic      in_ready,
	output logic      row_clear
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_MAC = 6'b000010, S_DIVS = 6'b000100,
		S_DIV = 6'b001000, S_OUT = 6'b010000, S_FLUSH = 6'b100000
	} state_t;
	state_t state_q;
	logic [2:0] tap_q;
	logic end_q;
	logic [1:0] fl_q;
	logic last_q;

	assign tap = tap_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		row_clear = 1'b0;
		cmd.load = in_fire;
		cmd.mac_clr = in_fire || (state_q == S_FLUSH);
		cmd.flush = (state_q == S_FLUSH) && (fl_q != 0);
		cmd.mac_step = (state_q == S_MAC);
		cmd.div_start = (state_q == S_DIVS);
		cmd.div_step = (state_q == S_DIV);
		cmd.emit = (state_q == S_OUT) && !sts.out_busy;
		cmd.last = last_q;
		row_clear = (state_q == S_FLUSH) && (fl_q == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q <= '0;
			end_q <= 1'b0;
			fl_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					end_q <= in_last;
					fl_q <= 2'd2;
					state_q <= S_MAC;
					tap_q <= '0;
				end
				S_MAC: begin
					// the count before the shift decides whether this step gives a result
					if (!sts.can_emit) state_q <= end_q ? S_FLUSH : S_IDLE;
					else if (tap_q == 3'd4) state_q <= S_DIVS;
					else tap_q <= tap_q + 3'd1;
				end
				S_DIVS: state_q <= S_DIV;
				S_DIV: if (sts.div_done) begin
					state_q <= S_OUT;
					last_q <= end_q && (fl_q == 0);
				end
				S_OUT: if (!sts.out_busy) state_q <= end_q ? S_FLUSH : S_IDLE;
				S_FLUSH: begin
					tap_q <= '0;
					if (fl_q == 0) begin
						state_q <= S_IDLE;
					end else begin
						fl_q <= fl_q - 2'd1;
						state_q <= S_MAC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/horizontal_convolution_5tap.sv]
// Five-tap horizontal filter with replicated row edges. Pixels arrive one per
// s_axis transaction, tlast marking the row end; each result is the weighted
// sum divided by the divisor, plus bias, rounded half up and clamped. A pixel
// that gives a result passes from one accepted transaction to the next ready
// through the idle state, the taps in turn in the shared multiply-accumulate
// unit, a set-up step, the bit-serial restoring divider and the load of the
// output register. The first two pixels of a row give no result. A row end
// adds two passes for the right-edge copies and a step to clear the row count.
// A result not yet taken at m_axis holds the next pass in its output step. A
// row of W pixels gives W results and the last one is flagged with tlast.
// Configuration writes are taken at once and belong between rows while the
// block is idle.
module horizontal_convolution_5tap
	import hc5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // pixel
	input  logic        s_axis_tlast,  // row_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_pixel
	output logic        m_axis_tlast,  // out_row_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	logic signed [15:0] coef_q [NUM_TAPS];
	logic [15:0] divisor_q, max_q;
	logic signed [16:0] bias_q;
	hc5_cmd_t cmd;
	hc5_sts_t sts;
	logic [2:0] tap;
	logic row_clear;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) coef_q[i] <= '0;
			coef_q[2] <= 16'sd1;
			divisor_q <= 16'd1;
			bias_q <= '0;
			max_q <= 16'd255;
		end else if (cfg_valid) begin
			if (cfg_index <= REG_COEF4) coef_q[cfg_index] <= cfg_data[15:0];
			else if (cfg_index == REG_DIVISOR) divisor_q <= cfg_data[15:0];
			else if (cfg_index == REG_BIAS) bias_q <= cfg_data;
			else if (cfg_index == REG_MAX) max_q <= cfg_data[15:0];
		end
	end

	hc5_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_axis_tlast), .sts, .cmd, .tap,
		.in_ready(s_axis_tready), .row_clear
	);

	hc5_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .tap, .px(s_axis_tdata[PIXEL_BITS-1:0]),
		.coef(coef_q), .divisor(divisor_q), .bias(bias_q), .max_value(max_q),
		.row_clear, .out_take(m_axis_tvalid && m_axis_tready),
		.out_valid(m_axis_tvalid), .out_pixel(m_axis_tdata), .out_row_end(m_axis_tlast)
	);

	// no new pixel while a pass is under way
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_step |-> !s_axis_tready) else $error("input taken mid pass");
	// a held result is never overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result overwritten");
endmodule
